// ===== rtl/tcgr_pkg.sv =====
package tcgr_pkg;

   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 64;

   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;

   localparam logic [7:0]  RST_GRID_COLUMNS  = 8'd80;
   localparam logic [6:0]  RST_GRID_ROWS     = 7'd25;
   localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd0;
   localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd0;
   localparam logic [31:0] RST_INK_COLOR     = 32'h00FF_FFFF;
   localparam logic [31:0] RST_PAPER_COLOR   = 32'h0000_0000;
   localparam logic        RST_ENABLED       = 1'b0;

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;

   typedef enum logic [1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      CSR_GRID_COLUMNS  = 3'd0,
      CSR_GRID_ROWS     = 3'd1,
      CSR_SCREEN_WIDTH  = 3'd2,
      CSR_SCREEN_HEIGHT = 3'd3,
      CSR_INK_COLOR     = 3'd4,
      CSR_PAPER_COLOR   = 3'd5,
      CSR_ENABLED       = 3'd6,
      CSR_UNUSED        = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_PIX_SPLIT,
      ST_PIX_ADDR,
      ST_PIX_READ,
      ST_PIX_SHADE,
      ST_PUT_PRE,
      ST_PUT_OP,
      ST_NL_WAIT,
      ST_PUT_POST,
      ST_SCR_READ,
      ST_SCR_MOVE,
      ST_SCR_BLANK,
      ST_DONE
   } state_type;

   // row 0 in the top byte, low five bits used
   typedef logic [6:0][7:0] glyph_type;

   localparam glyph_type DIGIT_FONT [10] = '{
      56'h0E_11_13_15_19_11_0E, 56'h04_0C_04_04_04_04_0E,
      56'h0E_11_01_02_04_08_1F, 56'h1E_01_01_0E_01_01_1E,
      56'h02_06_0A_12_1F_02_02, 56'h1F_10_10_1E_01_01_1E,
      56'h06_08_10_1E_11_11_0E, 56'h1F_01_02_04_08_08_08,
      56'h0E_11_11_0E_11_11_0E, 56'h0E_11_11_0F_01_02_0C
   };

   localparam glyph_type UPPER_FONT [26] = '{
      56'h0E_11_11_1F_11_11_11, 56'h1E_11_11_1E_11_11_1E,
      56'h0E_11_10_10_10_11_0E, 56'h1E_11_11_11_11_11_1E,
      56'h1F_10_10_1E_10_10_1F, 56'h1F_10_10_1E_10_10_10,
      56'h0E_11_10_17_11_11_0F, 56'h11_11_11_1F_11_11_11,
      56'h0E_04_04_04_04_04_0E, 56'h07_02_02_02_12_12_0C,
      56'h11_12_14_18_14_12_11, 56'h10_10_10_10_10_10_1F,
      56'h11_1B_15_15_11_11_11, 56'h11_19_15_13_11_11_11,
      56'h0E_11_11_11_11_11_0E, 56'h1E_11_11_1E_10_10_10,
      56'h0E_11_11_11_15_12_0D, 56'h1E_11_11_1E_14_12_11,
      56'h0F_10_10_0E_01_01_1E, 56'h1F_04_04_04_04_04_04,
      56'h11_11_11_11_11_11_0E, 56'h11_11_11_11_11_0A_04,
      56'h11_11_11_15_15_1B_11, 56'h11_11_0A_04_0A_11_11,
      56'h11_11_0A_04_04_04_04, 56'h1F_01_02_04_08_10_1F
   };

   localparam glyph_type LOWER_FONT [26] = '{
      56'h00_00_0E_01_0F_11_0F, 56'h10_10_16_19_11_11_1E,
      56'h00_00_0E_10_10_11_0E, 56'h01_01_0D_13_11_11_0F,
      56'h00_00_0E_11_1F_10_0E, 56'h06_08_08_1E_08_08_08,
      56'h00_00_0F_11_0F_01_0E, 56'h10_10_16_19_11_11_11,
      56'h04_00_0C_04_04_04_0E, 56'h02_00_06_02_02_12_0C,
      56'h10_10_12_14_18_14_12, 56'h0C_04_04_04_04_04_0E,
      56'h00_00_1A_15_15_15_15, 56'h00_00_16_19_11_11_11,
      56'h00_00_0E_11_11_11_0E, 56'h00_00_1E_11_1E_10_10,
      56'h00_00_0D_13_0F_01_01, 56'h00_00_16_19_10_10_10,
      56'h00_00_0F_10_0E_01_1E, 56'h08_08_1E_08_08_09_06,
      56'h00_00_11_11_11_13_0D, 56'h00_00_11_11_11_0A_04,
      56'h00_00_11_15_15_15_0A, 56'h00_00_11_0A_04_0A_11,
      56'h00_00_11_11_0F_01_0E, 56'h00_00_1F_02_04_08_1F
   };

   function automatic glyph_type glyph_of(input logic [7:0] code);
      glyph_type g;
      logic [7:0] ofs;
      g = 56'h0E_11_01_02_04_00_04;
      ofs = 8'h00;
      if (code inside {[8'h61:8'h7A]}) begin
         ofs = code - 8'h61;
         g = LOWER_FONT[ofs[4:0]];
      end else if (code inside {[8'h41:8'h5A]}) begin
         ofs = code - 8'h41;
         g = UPPER_FONT[ofs[4:0]];
      end else if (code inside {[8'h30:8'h39]}) begin
         ofs = code - 8'h30;
         g = DIGIT_FONT[ofs[3:0]];
      end else begin
         case (code)
            8'h20:   g = 56'h00_00_00_00_00_00_00;
            8'h2E:   g = 56'h00_00_00_00_00_00_04;
            8'h2C:   g = 56'h00_00_00_00_00_04_08;
            8'h3A:   g = 56'h00_00_04_00_00_04_00;
            8'h3B:   g = 56'h00_00_04_00_00_04_08;
            8'h2D:   g = 56'h00_00_00_1F_00_00_00;
            8'h5F:   g = 56'h00_00_00_00_00_00_1F;
            8'h2B:   g = 56'h00_04_04_1F_04_04_00;
            8'h3D:   g = 56'h00_00_1F_00_1F_00_00;
            8'h5C:   g = 56'h00_10_08_04_02_01_00;
            8'h2F:   g = 56'h00_01_02_04_08_10_00;
            8'h5B:   g = 56'h0E_08_08_08_08_08_0E;
            8'h5D:   g = 56'h0E_02_02_02_02_02_0E;
            8'h28:   g = 56'h02_04_08_08_08_04_02;
            8'h29:   g = 56'h08_04_02_02_02_04_08;
            8'h3E:   g = 56'h08_04_02_01_02_04_08;
            8'h3C:   g = 56'h02_04_08_10_08_04_02;
            8'h21:   g = 56'h04_04_04_04_04_00_04;
            8'h2A:   g = 56'h00_15_0E_1F_00_00_00;
            8'h27:   g = 56'h04_04_00_00_00_00_00;
            8'h22:   g = 56'h0A_0A_00_00_00_00_00;
            8'h7C:   g = 56'h04_04_04_04_04_04_04;
            default: g = 56'h0E_11_01_02_04_00_04;
         endcase
      end
      return g;
   endfunction

   function automatic logic [4:0] font_row(input logic [7:0] code, input logic [2:0] r);
      glyph_type g;
      logic [4:0] row;
      g = glyph_of(code);
      row = 5'd0;
      if (r < 3'(GLYPH_ROWS)) begin
         row = g[3'd6 - r][4:0];
      end
      return row;
   endfunction

endpackage

// ===== rtl/tcgr_ifs.sv =====
interface tcgr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  char_code;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   modport source (output valid, func, char_code, pixel_x, pixel_y, input ready);
   modport sink (input valid, func, char_code, pixel_x, pixel_y, output ready);
endinterface

interface tcgr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_value;
   logic        pixel_valid;
   logic [12:0] cursor_after;
   logic        scrolled;
   modport source (output valid, pixel_value, pixel_valid, cursor_after, scrolled,
                   input ready);
   modport sink (input valid, pixel_value, pixel_valid, cursor_after, scrolled,
                 output ready);
endinterface

interface tcgr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/tcgr_grid_mem.sv =====
module tcgr_grid_mem #(
   parameter int DEPTH = 8192,
   parameter int AW    = 13
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/tcgr_rem_unit.sv =====
module tcgr_rem_unit #(
   parameter int DW = 14,
   parameter int VW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [VW-1:0] remainder
);
   localparam int CNW = $clog2(DW + 1);

   logic [VW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  dvd_ff, dvd_in;
   logic [VW-1:0]  dsr_ff, dsr_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [VW:0]    trial;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[DW-1]};
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one restoring step per cycle
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = VW'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = VW'(trial);
         end
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff - CNW'(1);
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

// ===== rtl/text_console_glyph_renderer.sv =====
// Text console with a character grid and a 5x7 glyph renderer doubled into 12x16 cells.
// One item is worked at a time by a small sequencer around a grid memory with one write
// port and one read port; req ready is high only while the sequencer is idle. After reset
// the grid is swept to spaces, one cell a cycle, over all MAX_COLUMNS*MAX_ROWS cells before
// the first word is taken; a clear command runs the same sweep. A pixel read steps through
// the split, address, memory read and shade states to the rsp word; a newline put waits on
// the bit-serial remainder unit (DW being the cursor width), and each scroll moves every
// kept cell with one memory read and one write, then blanks the last row.
module text_console_glyph_renderer #(
   parameter int MAX_COLUMNS = tcgr_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = tcgr_pkg::DEF_MAX_ROWS
) (
   input  logic       clock,
   input  logic       reset,
   tcgr_req_if.sink   req_chan,
   tcgr_rsp_if.source rsp_chan,
   tcgr_csr_if.sink   csr_chan
);
   import tcgr_pkg::*;

   localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW    = $clog2(CELLS + 1);
   localparam int CLW   = $clog2(MAX_COLUMNS + 1);
   localparam int RLW   = $clog2(MAX_ROWS + 1);

   state_type   state_ff, state_in;

   logic [7:0]  csr_cols_ff;
   logic [6:0]  csr_rows_ff;
   logic [11:0] csr_width_ff;
   logic [11:0] csr_height_ff;
   logic [31:0] csr_ink_ff;
   logic [31:0] csr_paper_ff;
   logic        csr_en_ff;

   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic          phase_ff, phase_in;

   logic [1:0]  func_ff, func_in;
   logic [7:0]  code_ff, code_in;
   logic [11:0] px_ff, px_in;
   logic [11:0] py_ff, py_in;
   logic [8:0]  cx_ff, cx_in;
   logic [7:0]  cy_ff, cy_in;
   logic [2:0]  gc_ff, gc_in;
   logic [2:0]  gr_ff, gr_in;
   logic        inside_ff, inside_in;
   logic [31:0] value_ff, value_in;
   logic        valid_ff, valid_in;
   logic        scrolled_ff, scrolled_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic        rsp_pvalid_ff, rsp_pvalid_in;
   logic [CW-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic        rsp_scrolled_ff, rsp_scrolled_in;

   logic [CLW-1:0] cols;
   logic [RLW-1:0] rows;
   logic [CW-1:0]  cells;
   logic [CW-1:0]  keep;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;

   logic          div_start;
   logic          div_done;
   logic [CLW-1:0] div_rem;

   logic          req_fire;
   logic [9:0]    xv;
   logic [19:0]   xprod;
   logic [8:0]    xq;
   logic [9:0]    xq3;
   logic [1:0]    xr3;
   logic [4:0]    glyph_bits;
   logic          ink_bit;

   always_comb begin
      if (csr_cols_ff == '0) begin
         cols = CLW'(1);
      end else if (32'(csr_cols_ff) > 32'(MAX_COLUMNS)) begin
         cols = CLW'(MAX_COLUMNS);
      end else begin
         cols = CLW'(csr_cols_ff);
      end
      if (csr_rows_ff == '0) begin
         rows = RLW'(1);
      end else if (32'(csr_rows_ff) > 32'(MAX_ROWS)) begin
         rows = RLW'(MAX_ROWS);
      end else begin
         rows = RLW'(csr_rows_ff);
      end
   end

   assign cells = CW'(32'(cols) * 32'(rows));
   assign keep  = cells - CW'(cols);

   tcgr_grid_mem #(.DEPTH(CELLS), .AW(AW)) u_grid (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   tcgr_rem_unit #(.DW(CW), .VW(CLW)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cursor_ff),
      .divisor   (cols),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign csr_chan.ready = 1'b1;

   // x / 12 as (x / 4) / 3 by reciprocal
   assign xv    = px_ff[11:2];
   assign xprod = 20'(xv) * 20'd683;
   assign xq    = xprod[19:11];
   assign xq3   = {xq, 1'b0} + 10'(xq);
   assign xr3   = 2'(xv - xq3);

   assign glyph_bits = font_row(mem_rdata, gr_ff);
   assign ink_bit    = inside_ff && glyph_bits[3'd4 - gc_ff];

   assign mem_raddr = (state_ff == ST_SCR_READ) ? AW'(idx_ff + CW'(cols)) : AW'(idx_ff);

   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      idx_in      = idx_ff;
      clr_rsp_in  = clr_rsp_ff;
      phase_in    = phase_ff;
      func_in     = func_ff;
      code_in     = code_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      gc_in       = gc_ff;
      gr_in       = gr_ff;
      inside_in   = inside_ff;
      value_in    = value_ff;
      valid_in    = valid_ff;
      scrolled_in = scrolled_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in    = rsp_value_ff;
      rsp_pvalid_in   = rsp_pvalid_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(idx_ff);
      mem_wdata = CHAR_BLANK;
      div_start = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(CELLS - 1)) begin
               idx_in     = '0;
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               func_in     = req_chan.func;
               code_in     = req_chan.char_code;
               px_in       = req_chan.pixel_x;
               py_in       = req_chan.pixel_y;
               value_in    = '0;
               valid_in    = 1'b0;
               scrolled_in = 1'b0;
               phase_in    = 1'b0;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_DONE;
            case (func_ff)
               FUNC_READ: begin
                  if (px_ff < csr_width_ff && py_ff < csr_height_ff) begin
                     state_in = ST_PIX_SPLIT;
                  end
               end
               FUNC_PUT: begin
                  if (csr_en_ff) begin
                     state_in = ST_PUT_PRE;
                  end
               end
               FUNC_CLEAR: begin
                  if (csr_en_ff) begin
                     cursor_in  = '0;
                     idx_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_PIX_SPLIT: begin
            cx_in    = xq;
            gc_in    = {xr3, px_ff[1]};
            cy_in    = py_ff[11:4];
            gr_in    = py_ff[3:1];
            state_in = ST_PIX_ADDR;
         end
         ST_PIX_ADDR: begin
            inside_in = (32'(cx_ff) < 32'(cols)) && (32'(cy_ff) < 32'(rows)) &&
                        (gc_ff < 3'(GLYPH_COLS)) && (gr_ff < 3'(GLYPH_ROWS));
            idx_in    = CW'(32'(cy_ff) * 32'(cols) + 32'(cx_ff));
            state_in  = ST_PIX_READ;
         end
         ST_PIX_READ: begin
            state_in = ST_PIX_SHADE;
         end
         ST_PIX_SHADE: begin
            value_in = ink_bit ? csr_ink_ff : csr_paper_ff;
            valid_in = 1'b1;
            state_in = ST_DONE;
         end
         ST_PUT_PRE: begin
            if (cursor_ff >= cells) begin
               idx_in   = '0;
               state_in = (keep == '0) ? ST_SCR_BLANK : ST_SCR_READ;
            end else begin
               state_in = ST_PUT_OP;
            end
         end
         ST_PUT_OP: begin
            phase_in = 1'b1;
            state_in = ST_PUT_POST;
            if (code_ff == CHAR_NEWLINE) begin
               div_start = 1'b1;
               state_in  = ST_NL_WAIT;
            end else if (code_ff == CHAR_BACKSPACE) begin
               if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - CW'(1);
                  mem_we    = 1'b1;
                  mem_waddr = AW'(cursor_ff - CW'(1));
               end
            end else begin
               mem_we    = 1'b1;
               mem_waddr = AW'(cursor_ff);
               mem_wdata = code_ff;
               cursor_in = cursor_ff + CW'(1);
            end
         end
         ST_NL_WAIT: begin
            if (div_done) begin
               cursor_in = cursor_ff - CW'(div_rem) + CW'(cols);
               state_in  = ST_PUT_POST;
            end
         end
         ST_PUT_POST: begin
            if (cursor_ff >= cells) begin
               idx_in   = '0;
               state_in = (keep == '0) ? ST_SCR_BLANK : ST_SCR_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCR_READ: begin
            state_in = ST_SCR_MOVE;
         end
         ST_SCR_MOVE: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            idx_in    = idx_ff + CW'(1);
            state_in  = (idx_ff + CW'(1) == keep) ? ST_SCR_BLANK : ST_SCR_READ;
         end
         ST_SCR_BLANK: begin
            mem_we = 1'b1;
            idx_in = idx_ff + CW'(1);
            if (idx_ff + CW'(1) == cells) begin
               cursor_in   = keep;
               scrolled_in = 1'b1;
               state_in    = phase_ff ? ST_DONE : ST_PUT_OP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = value_ff;
               rsp_pvalid_in   = valid_ff;
               rsp_cursor_in   = cursor_ff;
               rsp_scrolled_in = scrolled_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cursor_ff     <= '0;
         idx_ff        <= '0;
         clr_rsp_ff    <= 1'b0;
         phase_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         csr_cols_ff   <= RST_GRID_COLUMNS;
         csr_rows_ff   <= RST_GRID_ROWS;
         csr_width_ff  <= RST_SCREEN_WIDTH;
         csr_height_ff <= RST_SCREEN_HEIGHT;
         csr_ink_ff    <= RST_INK_COLOR;
         csr_paper_ff  <= RST_PAPER_COLOR;
         csr_en_ff     <= RST_ENABLED;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         idx_ff       <= idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_GRID_COLUMNS:  csr_cols_ff   <= csr_chan.wdata[7:0];
               CSR_GRID_ROWS:     csr_rows_ff   <= csr_chan.wdata[6:0];
               CSR_SCREEN_WIDTH:  csr_width_ff  <= csr_chan.wdata[11:0];
               CSR_SCREEN_HEIGHT: csr_height_ff <= csr_chan.wdata[11:0];
               CSR_INK_COLOR:     csr_ink_ff    <= csr_chan.wdata;
               CSR_PAPER_COLOR:   csr_paper_ff  <= csr_chan.wdata;
               CSR_ENABLED:       csr_en_ff     <= csr_chan.wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      code_ff         <= code_in;
      px_ff           <= px_in;
      py_ff           <= py_in;
      cx_ff           <= cx_in;
      cy_ff           <= cy_in;
      gc_ff           <= gc_in;
      gr_ff           <= gr_in;
      inside_ff       <= inside_in;
      value_ff        <= value_in;
      valid_ff        <= valid_in;
      scrolled_ff     <= scrolled_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_pvalid_ff   <= rsp_pvalid_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pixel_value  = rsp_value_ff;
   assign rsp_chan.pixel_valid  = rsp_pvalid_ff;
   assign rsp_chan.cursor_after = 13'(rsp_cursor_ff);
   assign rsp_chan.scrolled     = rsp_scrolled_ff;
endmodule

// ===== tb/sv/tcgr_scoreboard.sv =====
`timescale 1ns / 1ps
module tcgr_scoreboard (
   input  logic clock,
   input  logic reset,
   tcgr_req_if  req,
   tcgr_rsp_if  rsp,
   tcgr_csr_if  csr,
   output int   fail_count,
   output int   pending
);
   import tcgr_pkg::*;

   typedef struct {
      logic [31:0] pixel_value;
      logic        pixel_valid;
      logic [12:0] cursor_after;
      logic        scrolled;
   } console_word_type;

   localparam int GRID_CELLS = DEF_MAX_COLUMNS * DEF_MAX_ROWS;

   logic [55:0] digit_rows [10] = '{
      56'h0E_11_13_15_19_11_0E, 56'h04_0C_04_04_04_04_0E,
      56'h0E_11_01_02_04_08_1F, 56'h1E_01_01_0E_01_01_1E,
      56'h02_06_0A_12_1F_02_02, 56'h1F_10_10_1E_01_01_1E,
      56'h06_08_10_1E_11_11_0E, 56'h1F_01_02_04_08_08_08,
      56'h0E_11_11_0E_11_11_0E, 56'h0E_11_11_0F_01_02_0C};
   logic [55:0] upper_rows [26] = '{
      56'h0E_11_11_1F_11_11_11, 56'h1E_11_11_1E_11_11_1E,
      56'h0E_11_10_10_10_11_0E, 56'h1E_11_11_11_11_11_1E,
      56'h1F_10_10_1E_10_10_1F, 56'h1F_10_10_1E_10_10_10,
      56'h0E_11_10_17_11_11_0F, 56'h11_11_11_1F_11_11_11,
      56'h0E_04_04_04_04_04_0E, 56'h07_02_02_02_12_12_0C,
      56'h11_12_14_18_14_12_11, 56'h10_10_10_10_10_10_1F,
      56'h11_1B_15_15_11_11_11, 56'h11_19_15_13_11_11_11,
      56'h0E_11_11_11_11_11_0E, 56'h1E_11_11_1E_10_10_10,
      56'h0E_11_11_11_15_12_0D, 56'h1E_11_11_1E_14_12_11,
      56'h0F_10_10_0E_01_01_1E, 56'h1F_04_04_04_04_04_04,
      56'h11_11_11_11_11_11_0E, 56'h11_11_11_11_11_0A_04,
      56'h11_11_11_15_15_1B_11, 56'h11_11_0A_04_0A_11_11,
      56'h11_11_0A_04_04_04_04, 56'h1F_01_02_04_08_10_1F};
   logic [55:0] lower_rows [26] = '{
      56'h00_00_0E_01_0F_11_0F, 56'h10_10_16_19_11_11_1E,
      56'h00_00_0E_10_10_11_0E, 56'h01_01_0D_13_11_11_0F,
      56'h00_00_0E_11_1F_10_0E, 56'h06_08_08_1E_08_08_08,
      56'h00_00_0F_11_0F_01_0E, 56'h10_10_16_19_11_11_11,
      56'h04_00_0C_04_04_04_0E, 56'h02_00_06_02_02_12_0C,
      56'h10_10_12_14_18_14_12, 56'h0C_04_04_04_04_04_0E,
      56'h00_00_1A_15_15_15_15, 56'h00_00_16_19_11_11_11,
      56'h00_00_0E_11_11_11_0E, 56'h00_00_1E_11_1E_10_10,
      56'h00_00_0D_13_0F_01_01, 56'h00_00_16_19_10_10_10,
      56'h00_00_0F_10_0E_01_1E, 56'h08_08_1E_08_08_09_06,
      56'h00_00_11_11_11_13_0D, 56'h00_00_11_11_11_0A_04,
      56'h00_00_11_15_15_15_0A, 56'h00_00_11_0A_04_0A_11,
      56'h00_00_11_11_0F_01_0E, 56'h00_00_1F_02_04_08_1F};
   logic [55:0] qmark = 56'h0E_11_01_02_04_00_04;

   logic [7:0]  char_grid [GRID_CELLS];
   int unsigned cursor_cell;
   logic [7:0]  grid_columns;
   logic [6:0]  grid_rows;
   logic [11:0] screen_width, screen_height;
   logic [31:0] ink_color, paper_color;
   logic        enabled;
   console_word_type expected_words [$];

   function automatic logic [4:0] row_bits(logic [7:0] code, int r);
      logic [55:0] g;
      if (code >= 8'h61 && code <= 8'h7A) begin
         g = lower_rows[code - 8'h61];
         return g[(6 - r) * 8 +: 5];
      end
      if (code >= 8'h41 && code <= 8'h5A) begin
         g = upper_rows[code - 8'h41];
         return g[(6 - r) * 8 +: 5];
      end
      if (code >= 8'h30 && code <= 8'h39) begin
         g = digit_rows[code - 8'h30];
         return g[(6 - r) * 8 +: 5];
      end
      case (code)
         8'h20: return 5'h00;
         8'h2E: return r == 6 ? 5'h04 : 5'h00;
         8'h2C: return r == 5 ? 5'h04 : (r == 6 ? 5'h08 : 5'h00);
         8'h3A: return (r == 2 || r == 5) ? 5'h04 : 5'h00;
         8'h3B: return (r == 2 || r == 5) ? 5'h04 : (r == 6 ? 5'h08 : 5'h00);
         8'h2D: return r == 3 ? 5'h1F : 5'h00;
         8'h5F: return r == 6 ? 5'h1F : 5'h00;
         8'h2B: return r == 3 ? 5'h1F : ((r == 0 || r == 6) ? 5'h00 : 5'h04);
         8'h3D: return (r == 2 || r == 4) ? 5'h1F : 5'h00;
         8'h5C: return (r >= 1 && r <= 5) ? 5'(1 << (5 - r)) : 5'h00;
         8'h2F: return (r >= 1 && r <= 5) ? 5'(1 << (r - 1)) : 5'h00;
         8'h5B: return (r == 0 || r == 6) ? 5'h0E : 5'h08;
         8'h5D: return (r == 0 || r == 6) ? 5'h0E : 5'h02;
         8'h28: return (r == 0 || r == 6) ? 5'h02 : ((r == 1 || r == 5) ? 5'h04 : 5'h08);
         8'h29: return (r == 0 || r == 6) ? 5'h08 : ((r == 1 || r == 5) ? 5'h04 : 5'h02);
         8'h3E: return r < 3 ? 5'(1 << (3 - r)) : 5'(1 << (r - 3));
         8'h3C: return r < 3 ? 5'(1 << (r + 1)) : 5'(1 << (7 - r));
         8'h21: return r == 5 ? 5'h00 : 5'h04;
         8'h2A: return r == 1 ? 5'h15 : (r == 2 ? 5'h0E : (r == 3 ? 5'h1F : 5'h00));
         8'h27: return r < 2 ? 5'h04 : 5'h00;
         8'h22: return r < 2 ? 5'h0A : 5'h00;
         8'h7C: return 5'h04;
         default: return qmark[(6 - r) * 8 +: 5];
      endcase
   endfunction

   function automatic int unsigned used_columns();
      if (grid_columns == 0) return 1;
      return grid_columns > DEF_MAX_COLUMNS ? DEF_MAX_COLUMNS : grid_columns;
   endfunction

   function automatic int unsigned used_rows();
      if (grid_rows == 0) return 1;
      return grid_rows > DEF_MAX_ROWS ? DEF_MAX_ROWS : grid_rows;
   endfunction

   task automatic blank_grid();
      for (int i = 0; i < GRID_CELLS; i++) char_grid[i] = CHAR_BLANK;
   endtask

   task automatic scroll_grid(int unsigned cols, int unsigned rows);
      int unsigned keep;
      keep = cols * (rows - 1);
      for (int unsigned i = 0; i < keep; i++) char_grid[i] = char_grid[i + cols];
      for (int unsigned i = 0; i < cols; i++) char_grid[keep + i] = CHAR_BLANK;
      cursor_cell = keep;
   endtask

   function automatic logic [31:0] shade_pixel(int unsigned x, int unsigned y);
      int unsigned cx, cy, gc, gr;
      logic [4:0] bits;
      cx = x / 12;
      cy = y / 16;
      gc = (x % 12) / 2;
      gr = (y % 16) / 2;
      if (cx >= used_columns() || cy >= used_rows() || gc >= 5 || gr >= 7)
         return paper_color;
      bits = row_bits(char_grid[cy * used_columns() + cx], gr);
      return bits[4 - gc] ? ink_color : paper_color;
   endfunction

   task automatic console_step(func_type f, logic [7:0] code, logic [11:0] px,
                               logic [11:0] py);
      console_word_type w;
      int unsigned cols, rows, cells;
      cols = used_columns();
      rows = used_rows();
      cells = cols * rows;
      w.pixel_value = '0;
      w.pixel_valid = 1'b0;
      w.scrolled = 1'b0;
      if (f == FUNC_PUT && enabled) begin
         if (cursor_cell >= cells) begin
            scroll_grid(cols, rows);
            w.scrolled = 1'b1;
         end
         if (code == CHAR_NEWLINE) begin
            cursor_cell = (cursor_cell / cols + 1) * cols;
         end else if (code == CHAR_BACKSPACE) begin
            if (cursor_cell > 0) begin
               cursor_cell--;
               char_grid[cursor_cell] = CHAR_BLANK;
            end
         end else begin
            char_grid[cursor_cell] = code;
            cursor_cell++;
         end
         if (cursor_cell >= cells) begin
            scroll_grid(cols, rows);
            w.scrolled = 1'b1;
         end
      end else if (f == FUNC_READ) begin
         if (px < screen_width && py < screen_height) begin
            w.pixel_valid = 1'b1;
            w.pixel_value = shade_pixel(px, py);
         end
      end else if (f == FUNC_CLEAR && enabled) begin
         blank_grid();
         cursor_cell = 0;
      end
      w.cursor_after = 13'(cursor_cell);
      expected_words.push_back(w);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      console_word_type w;
      if (reset) begin
         blank_grid();
         cursor_cell = 0;
         grid_columns = RST_GRID_COLUMNS;
         grid_rows = RST_GRID_ROWS;
         screen_width = RST_SCREEN_WIDTH;
         screen_height = RST_SCREEN_HEIGHT;
         ink_color = RST_INK_COLOR;
         paper_color = RST_PAPER_COLOR;
         enabled = RST_ENABLED;
         expected_words.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_GRID_COLUMNS:  grid_columns = csr.wdata[7:0];
               CSR_GRID_ROWS:     grid_rows = csr.wdata[6:0];
               CSR_SCREEN_WIDTH:  screen_width = csr.wdata[11:0];
               CSR_SCREEN_HEIGHT: screen_height = csr.wdata[11:0];
               CSR_INK_COLOR:     ink_color = csr.wdata;
               CSR_PAPER_COLOR:   paper_color = csr.wdata;
               CSR_ENABLED:       enabled = csr.wdata[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            console_step(func_type'(req.func), req.char_code, req.pixel_x, req.pixel_y);
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: result word with nothing expected", $time);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp.pixel_value !== w.pixel_value)
                  report("pixel_value", rsp.pixel_value, w.pixel_value);
               if (rsp.pixel_valid !== w.pixel_valid)
                  report("pixel_valid", rsp.pixel_valid, w.pixel_valid);
               if (rsp.cursor_after !== w.cursor_after)
                  report("cursor_after", rsp.cursor_after, w.cursor_after);
               if (rsp.scrolled !== w.scrolled)
                  report("scrolled", rsp.scrolled, w.scrolled);
            end
         end
      end
      pending = expected_words.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import tcgr_pkg::*;

   localparam longint CYCLE_LIMIT = 100000000;

   logic   clock;
   logic   reset;
   int     fail_count;
   int     pending;
   int     gap_pct;
   int     stall_pct;
   longint cycles;
   int     cur_cols, cur_rows;

   tcgr_req_if req_if ();
   tcgr_rsp_if rsp_if ();
   tcgr_csr_if csr_if ();

   text_console_glyph_renderer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   tcgr_scoreboard checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr        (csr_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycles = 0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_GRID_COLUMNS)
         cur_cols = data[7:0] == 0 ? 1 : (data[7:0] > 128 ? 128 : data[7:0]);
      if (idx == CSR_GRID_ROWS)
         cur_rows = data[6:0] == 0 ? 1 : (data[6:0] > 64 ? 64 : data[6:0]);
   endtask

   task automatic send_word(func_type f, logic [7:0] code, logic [11:0] px, logic [11:0] py);
      while ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func <= f;
      req_if.char_code <= code;
      req_if.pixel_x <= px;
      req_if.pixel_y <= py;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic read_near(int unsigned px, int unsigned py);
      send_word(FUNC_READ, 8'h00, 12'(px), 12'(py));
   endtask

   task automatic random_settings();
      int k;
      k = $urandom_range(7);
      if (k == 0) write_csr(CSR_GRID_COLUMNS, $urandom_range(255));
      else write_csr(CSR_GRID_COLUMNS, $urandom_range(8));
      k = $urandom_range(7);
      if (k == 0) write_csr(CSR_GRID_ROWS, $urandom_range(127));
      else write_csr(CSR_GRID_ROWS, $urandom_range(5));
      write_csr(CSR_SCREEN_WIDTH, $urandom_range(3) == 0 ? $urandom_range(4095) : 4095);
      write_csr(CSR_SCREEN_HEIGHT, $urandom_range(3) == 0 ? $urandom_range(4095) : 4095);
      write_csr(CSR_INK_COLOR, $urandom());
      write_csr(CSR_PAPER_COLOR, $urandom());
      write_csr(CSR_ENABLED, $urandom_range(7) != 0);
   endtask

   task automatic random_word();
      int k;
      logic [7:0] code;
      k = $urandom_range(99);
      if (k < 52) begin
         case ($urandom_range(9))
            0:       code = CHAR_NEWLINE;
            1:       code = CHAR_BACKSPACE;
            2:       code = 8'($urandom_range(255));
            default: code = 8'($urandom_range(126, 32));
         endcase
         send_word(FUNC_PUT, code, 12'($urandom()), 12'($urandom()));
      end else if (k < 94) begin
         if ($urandom_range(4) == 0)
            read_near($urandom_range(4095), $urandom_range(4095));
         else
            read_near($urandom_range(cur_cols * 12 + 11), $urandom_range(cur_rows * 16 + 15));
      end else if (k < 96) begin
         send_word(FUNC_CLEAR, 8'($urandom()), 12'($urandom()), 12'($urandom()));
      end else begin
         send_word(FUNC_NOP, 8'($urandom()), 12'($urandom()), 12'($urandom()));
      end
   endtask

   initial begin
      reset = 1'b1;
      gap_pct = 0;
      stall_pct = 0;
      cur_cols = 80;
      cur_rows = 25;
      req_if.valid = 1'b0;
      req_if.func = FUNC_NOP;
      req_if.char_code = '0;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_GRID_COLUMNS;
      csr_if.wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // disabled console and empty screen
      send_word(FUNC_PUT, 8'h41, 12'h0, 12'h0);
      send_word(FUNC_CLEAR, 8'h0, 12'h0, 12'h0);
      send_word(FUNC_READ, 8'h0, 12'h0, 12'h0);
      drain();
      write_csr(CSR_GRID_COLUMNS, 4);
      write_csr(CSR_GRID_ROWS, 3);
      write_csr(CSR_SCREEN_WIDTH, 60);
      write_csr(CSR_SCREEN_HEIGHT, 56);
      write_csr(CSR_INK_COLOR, 32'hFFFF_FFFF);
      write_csr(CSR_PAPER_COLOR, 32'h1234_5678);
      write_csr(CSR_ENABLED, 1);
      send_word(FUNC_PUT, CHAR_BACKSPACE, 12'h0, 12'h0);
      send_word(FUNC_PUT, 8'h41, 12'h0, 12'h0);
      send_word(FUNC_PUT, 8'hFF, 12'h0, 12'h0);
      send_word(FUNC_PUT, 8'h20, 12'h0, 12'h0);
      send_word(FUNC_PUT, CHAR_NEWLINE, 12'h0, 12'h0);
      send_word(FUNC_PUT, 8'h7A, 12'h0, 12'h0);
      send_word(FUNC_PUT, CHAR_BACKSPACE, 12'h0, 12'h0);
      send_word(FUNC_PUT, 8'h30, 12'h0, 12'h0);
      read_near(4, 0);
      read_near(14, 2);
      read_near(10, 14);
      read_near(59, 55);
      read_near(60, 3);
      read_near(4095, 4095);
      send_word(FUNC_NOP, 8'hFF, 12'hFFF, 12'hFFF);
      send_word(FUNC_PUT, CHAR_NEWLINE, 12'h0, 12'h0);
      send_word(FUNC_PUT, CHAR_NEWLINE, 12'h0, 12'h0);
      drain();
      // cursor left beyond a shrunk grid
      write_csr(CSR_GRID_COLUMNS, 0);
      write_csr(CSR_GRID_ROWS, 0);
      send_word(FUNC_PUT, 8'h7C, 12'h0, 12'h0);
      read_near(2, 2);
      send_word(FUNC_CLEAR, 8'h0, 12'h0, 12'h0);
      drain();
      write_csr(CSR_GRID_COLUMNS, 255);
      write_csr(CSR_GRID_ROWS, 127);
      write_csr(CSR_SCREEN_WIDTH, 4095);
      write_csr(CSR_SCREEN_HEIGHT, 4095);
      write_csr(CSR_INK_COLOR, 0);
      write_csr(CSR_PAPER_COLOR, 32'hFFFF_FFFF);
      send_word(FUNC_PUT, 8'h2A, 12'h0, 12'h0);
      read_near(1535, 1023);
      read_near(4, 2);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 57; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 57; end
            default: begin gap_pct = 7; stall_pct = 7; end
         endcase
         for (int part = 0; part < 8; part++) begin
            random_settings();
            for (int n = 0; n < 17; n++) random_word();
            drain();
         end
      end

      stall_pct = 0;
      drain();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
